### rtl/afu_pkg.sv
// Shared constants, opcodes and control types of the activation function unit.
package afu_pkg;

   localparam int DEF_VALUE_WIDTH   = 24;
   localparam int DEF_FRACTION_BITS = 16;
   localparam int OPCODE_WIDTH      = 3;
   localparam int LIMIT_WIDTH       = 24;
   localparam int EXP_LIMIT_WIDTH   = 23;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 24;
   localparam int TAYLOR_TERMS      = 20;
   localparam int SQUARE_STEPS      = 8;
   localparam int EXP_INT_BITS      = 6;
   localparam int SQUARE_SHIFT      = 8;
   localparam int Q_WIDTH           = 64;
   localparam int Q_HALF            = 32;
   localparam int Q_POINT           = 62;

   localparam logic [Q_WIDTH-1:0] ONE_Q62 = 64'h4000_0000_0000_0000;

   localparam logic [LIMIT_WIDTH-1:0]     SIGMOID_LOW_RESET  = 24'hD80000;
   localparam logic [LIMIT_WIDTH-1:0]     SIGMOID_HIGH_RESET = 24'h0D0000;
   localparam logic [EXP_LIMIT_WIDTH-1:0] EXP_LIMIT_RESET    = 23'h280000;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_RELU          = 3'd0,
      OP_SIGMOID       = 3'd1,
      OP_TANH          = 3'd2,
      OP_IDENTITY      = 3'd3,
      OP_RELU_GRAD     = 3'd4,
      OP_SIGMOID_GRAD  = 3'd5,
      OP_TANH_GRAD     = 3'd6,
      OP_IDENTITY_GRAD = 3'd7
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SIGMOID_LOW  = 2'd0,
      CSR_SIGMOID_HIGH = 2'd1,
      CSR_EXP_LIMIT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      opcode_type op;
      logic       negate;
      logic       positive;
      logic       exp_zero;
   } tag_type;

endpackage

### rtl/afu_if.sv
// Request and response stream interfaces of the activation function unit.
interface afu_req_if #(parameter int VALUE_WIDTH = afu_pkg::DEF_VALUE_WIDTH);
   logic                                 valid;
   logic                                 ready;
   logic [afu_pkg::OPCODE_WIDTH-1:0]     opcode;
   logic signed [VALUE_WIDTH-1:0]        value_a;
   logic signed [VALUE_WIDTH-1:0]        value_b;

   modport source (output valid, output opcode, output value_a, output value_b, input ready);
   modport sink (input valid, input opcode, input value_a, input value_b, output ready);
endinterface

interface afu_rsp_if #(parameter int VALUE_WIDTH = afu_pkg::DEF_VALUE_WIDTH);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] result;
   logic                          saturated;

   modport source (output valid, output result, output saturated, input ready);
   modport sink (input valid, input result, input saturated, output ready);
endinterface

### rtl/afu_front.sv
// Operand decode, input clamping and the pipelined gradient triple product.
module afu_front #(
   parameter int VALUE_WIDTH   = afu_pkg::DEF_VALUE_WIDTH,
   parameter int FRACTION_BITS = afu_pkg::DEF_FRACTION_BITS
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               enable,
   input  logic                                               in_valid,
   input  afu_pkg::opcode_type                                opcode,
   input  logic signed [VALUE_WIDTH-1:0]                      value_a,
   input  logic signed [VALUE_WIDTH-1:0]                      value_b,
   input  logic signed [afu_pkg::LIMIT_WIDTH-1:0]             sigmoid_low,
   input  logic signed [afu_pkg::LIMIT_WIDTH-1:0]             sigmoid_high,
   input  logic [afu_pkg::EXP_LIMIT_WIDTH-1:0]                exponent_limit,
   output logic                                               out_valid,
   output afu_pkg::tag_type                                   out_tag,
   output logic [FRACTION_BITS+afu_pkg::EXP_INT_BITS-1:0]     out_arg,
   output logic [VALUE_WIDTH-1:0]                             out_side_result,
   output logic                                               out_side_sat
);
   localparam int UW  = FRACTION_BITS + afu_pkg::EXP_INT_BITS;
   localparam int TW  = VALUE_WIDTH + 2;
   localparam int PW  = 2 * TW;
   localparam int FW  = 3 * TW;
   localparam int MW0 = VALUE_WIDTH > afu_pkg::LIMIT_WIDTH ? VALUE_WIDTH : afu_pkg::LIMIT_WIDTH;
   localparam int MW1 = UW > MW0 ? UW : MW0;
   localparam int MW  = MW1 + 2;
   localparam logic [TW-1:0] ONE_FIX = TW'(1) << FRACTION_BITS;

   logic signed [MW-1:0] a_ext, low_ext, high_ext, lim_ext, x_clamp, t_neg2, t_clamp, arg_sel;
   logic [MW-1:0]        mag_in;
   logic signed [TW-1:0] ta, tb, ty, tz;
   logic [TW-1:0]        tx_in, ty_in, tz_in;
   logic                 tneg_in;
   logic [VALUE_WIDTH-1:0] side_in;
   afu_pkg::tag_type     tag_in;

   always_comb begin
      a_ext    = MW'(value_a);
      low_ext  = MW'(sigmoid_low);
      high_ext = MW'(sigmoid_high);
      lim_ext  = signed'(MW'(exponent_limit));
      if (a_ext < low_ext) begin
         x_clamp = low_ext;
      end else if (a_ext > high_ext) begin
         x_clamp = high_ext;
      end else begin
         x_clamp = a_ext;
      end
      t_neg2  = -(a_ext <<< 1);
      t_clamp = (t_neg2 > lim_ext) ? lim_ext : t_neg2;
      arg_sel = (opcode == afu_pkg::OP_TANH) ? t_clamp : x_clamp;
      mag_in  = arg_sel[MW-1] ? unsigned'(-arg_sel) : unsigned'(arg_sel);
      tag_in.op       = opcode;
      tag_in.negate   = (opcode == afu_pkg::OP_TANH) && (t_clamp > 0);
      tag_in.positive = !x_clamp[MW-1];
      tag_in.exp_zero = 1'b0;

      ta = TW'(value_a);
      tb = TW'(value_b);
      if (opcode == afu_pkg::OP_SIGMOID_GRAD) begin
         ty = tb;
         tz = signed'(ONE_FIX) - tb;
      end else begin
         ty = signed'(ONE_FIX) - tb;
         tz = signed'(ONE_FIX) + tb;
      end
      tx_in   = ta[TW-1] ? unsigned'(-ta) : unsigned'(ta);
      ty_in   = ty[TW-1] ? unsigned'(-ty) : unsigned'(ty);
      tz_in   = tz[TW-1] ? unsigned'(-tz) : unsigned'(tz);
      tneg_in = ta[TW-1] ^ ty[TW-1] ^ tz[TW-1];

      case (opcode)
         afu_pkg::OP_RELU:          side_in = (value_a > 0) ? value_a : '0;
         afu_pkg::OP_RELU_GRAD:     side_in = (value_b > 0) ? value_a : '0;
         afu_pkg::OP_IDENTITY:      side_in = value_a;
         afu_pkg::OP_IDENTITY_GRAD: side_in = value_a;
         default:                   side_in = '0;
      endcase
   end

   logic                   s0_valid_ff, s1_valid_ff, s2_valid_ff;
   afu_pkg::tag_type       s0_tag_ff, s1_tag_ff, s2_tag_ff;
   logic [MW-1:0]          s0_mag_ff;
   logic [UW-1:0]          s1_arg_ff, s2_arg_ff;
   logic [TW-1:0]          s0_tx_ff, s0_ty_ff, s0_tz_ff, s1_tz_ff;
   logic                   s0_tneg_ff, s1_tneg_ff, s2_tneg_ff;
   logic [VALUE_WIDTH-1:0] s0_side_ff, s1_side_ff, s2_side_ff;
   logic [PW-1:0]          s1_p_ff, s2_plo_ff, s2_phi_ff;
   afu_pkg::tag_type       s1_tag_in;

   always_comb begin
      s1_tag_in          = s0_tag_ff;
      s1_tag_in.exp_zero = (s0_mag_ff[MW-1:UW] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid   <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         out_valid   <= s2_valid_ff;
      end
   end

   logic [FW-1:0]          full, n_raw, lim, n_sat;
   logic                   t_sat;
   logic [VALUE_WIDTH-1:0] t_result;
   logic                   use_triple;

   always_comb begin
      full  = (FW'(s2_phi_ff) << TW) + FW'(s2_plo_ff) + (FW'(1) << (2 * FRACTION_BITS - 1));
      n_raw = full >> (2 * FRACTION_BITS);
      lim   = (FW'(1) << (VALUE_WIDTH - 1)) - FW'(1) + FW'(s2_tneg_ff);
      t_sat = n_raw > lim;
      n_sat = t_sat ? lim : n_raw;
      t_result = VALUE_WIDTH'(s2_tneg_ff ? (~n_sat + FW'(1)) : n_sat);
      use_triple = (s2_tag_ff.op == afu_pkg::OP_SIGMOID_GRAD) ||
                   (s2_tag_ff.op == afu_pkg::OP_TANH_GRAD);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_tag_ff  <= tag_in;
         s0_mag_ff  <= mag_in;
         s0_tx_ff   <= tx_in;
         s0_ty_ff   <= ty_in;
         s0_tz_ff   <= tz_in;
         s0_tneg_ff <= tneg_in;
         s0_side_ff <= side_in;

         s1_tag_ff  <= s1_tag_in;
         s1_arg_ff  <= s0_mag_ff[UW-1:0];
         s1_p_ff    <= PW'(s0_tx_ff) * PW'(s0_ty_ff);
         s1_tz_ff   <= s0_tz_ff;
         s1_tneg_ff <= s0_tneg_ff;
         s1_side_ff <= s0_side_ff;

         s2_tag_ff  <= s1_tag_ff;
         s2_arg_ff  <= s1_arg_ff;
         s2_plo_ff  <= PW'(s1_p_ff[TW-1:0]) * PW'(s1_tz_ff);
         s2_phi_ff  <= PW'(s1_p_ff[PW-1:TW]) * PW'(s1_tz_ff);
         s2_tneg_ff <= s1_tneg_ff;
         s2_side_ff <= s1_side_ff;

         out_tag         <= s2_tag_ff;
         out_arg         <= s2_arg_ff;
         out_side_result <= use_triple ? t_result : s2_side_ff;
         out_side_sat    <= use_triple && t_sat;
      end
   end
endmodule

### rtl/afu_taylor_step.sv
// One Taylor series term of the exponential: multiply, reciprocal divide, then accumulate.
module afu_taylor_step #(
   parameter int VALUE_WIDTH   = afu_pkg::DEF_VALUE_WIDTH,
   parameter int FRACTION_BITS = afu_pkg::DEF_FRACTION_BITS,
   parameter int ORDER         = 1
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           enable,
   input  logic                                           in_valid,
   input  afu_pkg::tag_type                               in_tag,
   input  logic [FRACTION_BITS+afu_pkg::EXP_INT_BITS-1:0] in_arg,
   input  logic [afu_pkg::Q_WIDTH-1:0]                    in_term,
   input  logic [afu_pkg::Q_WIDTH-1:0]                    in_y,
   input  logic [VALUE_WIDTH-1:0]                         in_side_result,
   input  logic                                           in_side_sat,
   output logic                                           out_valid,
   output afu_pkg::tag_type                               out_tag,
   output logic [FRACTION_BITS+afu_pkg::EXP_INT_BITS-1:0] out_arg,
   output logic [afu_pkg::Q_WIDTH-1:0]                    out_term,
   output logic [afu_pkg::Q_WIDTH-1:0]                    out_y,
   output logic [VALUE_WIDTH-1:0]                         out_side_result,
   output logic                                           out_side_sat
);
   localparam int UW = FRACTION_BITS + afu_pkg::EXP_INT_BITS;
   localparam int HW = afu_pkg::Q_HALF + UW;
   localparam int PW = afu_pkg::Q_WIDTH + UW;
   localparam int QH = afu_pkg::Q_HALF;
   localparam int QW = afu_pkg::Q_WIDTH;
   localparam int RL = $clog2(ORDER);
   localparam int CW = QW + 8;
   localparam int SW = 2 * QW + 8;

   // The quotient by ORDER is taken as a multiply by the rounded-up reciprocal,
   // which is exact for every 64-bit dividend.
   localparam logic [CW-1:0] RECIP =
      ((CW'(1) << (QW + RL)) + CW'(ORDER - 1)) / CW'(ORDER);
   localparam logic [QH-1:0] RECIP_LO  = RECIP[QH-1:0];
   localparam logic [QH-1:0] RECIP_MID = RECIP[QW-1:QH];
   localparam logic [QH-1:0] RECIP_HI  = QH'(RECIP[CW-1:QW]);

   logic                   a_valid_ff;
   afu_pkg::tag_type       a_tag_ff;
   logic [UW-1:0]          a_arg_ff;
   logic [QW-1:0]          a_y_ff;
   logic [VALUE_WIDTH-1:0] a_side_ff;
   logic                   a_sat_ff;
   logic [HW-1:0]          a_plo_ff, a_phi_ff;

   logic                   b_valid_ff;
   afu_pkg::tag_type       b_tag_ff;
   logic [UW-1:0]          b_arg_ff;
   logic [QW-1:0]          b_y_ff;
   logic [VALUE_WIDTH-1:0] b_side_ff;
   logic                   b_sat_ff;
   logic [QW-1:0]          b_p00_ff, b_p01_ff, b_p10_ff, b_p11_ff, b_p02_ff, b_p12_ff;

   logic [PW-1:0] prod;
   logic [SW-1:0] sum;
   logic [QW-1:0] scaled, q_in, y_in;

   always_comb begin
      prod   = (PW'(a_phi_ff) << QH) + PW'(a_plo_ff);
      scaled = QW'(prod >> (afu_pkg::SQUARE_SHIFT + FRACTION_BITS));
      sum    = SW'(b_p00_ff) + (SW'(b_p01_ff) << QH) + (SW'(b_p10_ff) << QH) +
               (SW'(b_p11_ff) << QW) + (SW'(b_p02_ff) << QW) +
               (SW'(b_p12_ff) << (QW + QH));
      q_in   = QW'(sum >> (QW + RL));
      y_in   = (ORDER % 2 == 1) ? (b_y_ff - q_in) : (b_y_ff + q_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         out_valid  <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         out_valid  <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_tag_ff  <= in_tag;
         a_arg_ff  <= in_arg;
         a_y_ff    <= in_y;
         a_side_ff <= in_side_result;
         a_sat_ff  <= in_side_sat;
         a_plo_ff  <= HW'(in_term[QH-1:0]) * HW'(in_arg);
         a_phi_ff  <= HW'(in_term[QW-1:QH]) * HW'(in_arg);

         b_tag_ff  <= a_tag_ff;
         b_arg_ff  <= a_arg_ff;
         b_y_ff    <= a_y_ff;
         b_side_ff <= a_side_ff;
         b_sat_ff  <= a_sat_ff;
         b_p00_ff  <= QW'(scaled[QH-1:0]) * QW'(RECIP_LO);
         b_p01_ff  <= QW'(scaled[QH-1:0]) * QW'(RECIP_MID);
         b_p02_ff  <= QW'(scaled[QH-1:0]) * QW'(RECIP_HI);
         b_p10_ff  <= QW'(scaled[QW-1:QH]) * QW'(RECIP_LO);
         b_p11_ff  <= QW'(scaled[QW-1:QH]) * QW'(RECIP_MID);
         b_p12_ff  <= QW'(scaled[QW-1:QH]) * QW'(RECIP_HI);

         out_tag         <= b_tag_ff;
         out_arg         <= b_arg_ff;
         out_term        <= q_in;
         out_y           <= y_in;
         out_side_result <= b_side_ff;
         out_side_sat    <= b_sat_ff;
      end
   end
endmodule

### rtl/afu_square_step.sv
// One truncating fixed-point squaring of the exponential, split into two stages.
module afu_square_step #(
   parameter int VALUE_WIDTH = afu_pkg::DEF_VALUE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  afu_pkg::tag_type            in_tag,
   input  logic [afu_pkg::Q_WIDTH-1:0] in_y,
   input  logic [VALUE_WIDTH-1:0]      in_side_result,
   input  logic                        in_side_sat,
   output logic                        out_valid,
   output afu_pkg::tag_type            out_tag,
   output logic [afu_pkg::Q_WIDTH-1:0] out_y,
   output logic [VALUE_WIDTH-1:0]      out_side_result,
   output logic                        out_side_sat
);
   localparam int QW = afu_pkg::Q_WIDTH;
   localparam int QH = afu_pkg::Q_HALF;
   localparam int DW = 2 * QW;

   logic                   a_valid_ff;
   afu_pkg::tag_type       a_tag_ff;
   logic [VALUE_WIDTH-1:0] a_side_ff;
   logic                   a_sat_ff;
   logic [QW-1:0]          a_hh_ff, a_hl_ff, a_ll_ff;
   logic [DW-1:0]          full;

   always_comb begin
      full = (DW'(a_hh_ff) << QW) + (DW'(a_hl_ff) << (QH + 1)) + DW'(a_ll_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         out_valid  <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         out_valid  <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_tag_ff  <= in_tag;
         a_side_ff <= in_side_result;
         a_sat_ff  <= in_side_sat;
         a_hh_ff   <= QW'(in_y[QW-1:QH]) * QW'(in_y[QW-1:QH]);
         a_hl_ff   <= QW'(in_y[QW-1:QH]) * QW'(in_y[QH-1:0]);
         a_ll_ff   <= QW'(in_y[QH-1:0]) * QW'(in_y[QH-1:0]);

         out_tag         <= a_tag_ff;
         out_y           <= full[afu_pkg::Q_POINT+QW-1:afu_pkg::Q_POINT];
         out_side_result <= a_side_ff;
         out_side_sat    <= a_sat_ff;
      end
   end
endmodule

### rtl/afu_div_step.sv
// One restoring division step that produces one quotient bit per stage.
module afu_div_step #(
   parameter int VALUE_WIDTH   = afu_pkg::DEF_VALUE_WIDTH,
   parameter int FRACTION_BITS = afu_pkg::DEF_FRACTION_BITS,
   parameter bit FIRST         = 1'b0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  afu_pkg::tag_type            in_tag,
   input  logic [afu_pkg::Q_WIDTH-1:0] in_num,
   input  logic [afu_pkg::Q_WIDTH-1:0] in_den,
   input  logic [FRACTION_BITS+1:0]    in_quot,
   input  logic [VALUE_WIDTH-1:0]      in_side_result,
   input  logic                        in_side_sat,
   output logic                        out_valid,
   output afu_pkg::tag_type            out_tag,
   output logic [afu_pkg::Q_WIDTH-1:0] out_num,
   output logic [afu_pkg::Q_WIDTH-1:0] out_den,
   output logic [FRACTION_BITS+1:0]    out_quot,
   output logic [VALUE_WIDTH-1:0]      out_side_result,
   output logic                        out_side_sat
);
   logic [afu_pkg::Q_WIDTH-1:0] num_s, num_in;
   logic [FRACTION_BITS+1:0]    quot_s, quot_in;

   always_comb begin
      num_s  = FIRST ? in_num : (in_num << 1);
      quot_s = FIRST ? in_quot : (in_quot << 1);
      if (num_s >= in_den) begin
         num_in  = num_s - in_den;
         quot_in = quot_s | (FRACTION_BITS + 2)'(1);
      end else begin
         num_in  = num_s;
         quot_in = quot_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (enable) begin
         out_valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_tag         <= in_tag;
         out_num         <= num_in;
         out_den         <= in_den;
         out_quot        <= quot_in;
         out_side_result <= in_side_result;
         out_side_sat    <= in_side_sat;
      end
   end
endmodule

### rtl/activation_function_unit.sv
// Top level of the pipelined fixed-point activation function unit.
// The unit takes one request per cycle and returns one response per request, in order.
// Every request, whatever its opcode, walks the same pipeline of 4 + 3*20 + 2*8 +
// (FRACTION_BITS + 2) + 1 register stages, with a default Q8.16 format: four stages of
// decode and gradient product, three per Taylor term of the exponential, two per squaring,
// one per quotient bit of the final division and one output register. When the response
// is not taken the whole pipeline holds. Configuration registers are written through the
// csr port; users must do so only while no request is in flight, unchecked by the block.
module activation_function_unit #(
   parameter int VALUE_WIDTH   = afu_pkg::DEF_VALUE_WIDTH,
   parameter int FRACTION_BITS = afu_pkg::DEF_FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   afu_req_if.sink                              req_ch,
   afu_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [afu_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [afu_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   localparam int UW = FRACTION_BITS + afu_pkg::EXP_INT_BITS;
   localparam int QW = afu_pkg::Q_WIDTH;
   localparam int NT = afu_pkg::TAYLOR_TERMS;
   localparam int NS = afu_pkg::SQUARE_STEPS;
   localparam int ND = FRACTION_BITS + 2;
   localparam int DW = FRACTION_BITS + 2;
   localparam int RW = (DW + 1 > VALUE_WIDTH ? DW + 1 : VALUE_WIDTH) + 1;

   logic [afu_pkg::LIMIT_WIDTH-1:0]     sigmoid_low_ff, sigmoid_high_ff;
   logic [afu_pkg::EXP_LIMIT_WIDTH-1:0] exponent_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigmoid_low_ff    <= afu_pkg::SIGMOID_LOW_RESET;
         sigmoid_high_ff   <= afu_pkg::SIGMOID_HIGH_RESET;
         exponent_limit_ff <= afu_pkg::EXP_LIMIT_RESET;
      end else if (csr_we) begin
         case (afu_pkg::csr_index_type'(csr_index))
            afu_pkg::CSR_SIGMOID_LOW:  sigmoid_low_ff    <= csr_wdata[afu_pkg::LIMIT_WIDTH-1:0];
            afu_pkg::CSR_SIGMOID_HIGH: sigmoid_high_ff   <= csr_wdata[afu_pkg::LIMIT_WIDTH-1:0];
            afu_pkg::CSR_EXP_LIMIT:
               exponent_limit_ff <= csr_wdata[afu_pkg::EXP_LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   logic enable;

   assign enable       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = enable;

   logic                   tay_valid [0:NT];
   afu_pkg::tag_type       tay_tag   [0:NT];
   logic [UW-1:0]          tay_arg   [0:NT];
   logic [QW-1:0]          tay_term  [0:NT];
   logic [QW-1:0]          tay_y     [0:NT];
   logic [VALUE_WIDTH-1:0] tay_side  [0:NT];
   logic                   tay_sat   [0:NT];

   afu_front #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .enable          (enable),
      .in_valid        (req_ch.valid),
      .opcode          (afu_pkg::opcode_type'(req_ch.opcode)),
      .value_a         (req_ch.value_a),
      .value_b         (req_ch.value_b),
      .sigmoid_low     (sigmoid_low_ff),
      .sigmoid_high    (sigmoid_high_ff),
      .exponent_limit  (exponent_limit_ff),
      .out_valid       (tay_valid[0]),
      .out_tag         (tay_tag[0]),
      .out_arg         (tay_arg[0]),
      .out_side_result (tay_side[0]),
      .out_side_sat    (tay_sat[0])
   );

   assign tay_term[0] = afu_pkg::ONE_Q62;
   assign tay_y[0]    = afu_pkg::ONE_Q62;

   for (genvar i = 0; i < NT; i++) begin : g_taylor
      afu_taylor_step #(
         .VALUE_WIDTH   (VALUE_WIDTH),
         .FRACTION_BITS (FRACTION_BITS),
         .ORDER         (i + 1)
      ) u_step (
         .clock           (clock),
         .reset           (reset),
         .enable          (enable),
         .in_valid        (tay_valid[i]),
         .in_tag          (tay_tag[i]),
         .in_arg          (tay_arg[i]),
         .in_term         (tay_term[i]),
         .in_y            (tay_y[i]),
         .in_side_result  (tay_side[i]),
         .in_side_sat     (tay_sat[i]),
         .out_valid       (tay_valid[i+1]),
         .out_tag         (tay_tag[i+1]),
         .out_arg         (tay_arg[i+1]),
         .out_term        (tay_term[i+1]),
         .out_y           (tay_y[i+1]),
         .out_side_result (tay_side[i+1]),
         .out_side_sat    (tay_sat[i+1])
      );
   end

   logic                   sq_valid [0:NS];
   afu_pkg::tag_type       sq_tag   [0:NS];
   logic [QW-1:0]          sq_y     [0:NS];
   logic [VALUE_WIDTH-1:0] sq_side  [0:NS];
   logic                   sq_sat   [0:NS];

   assign sq_valid[0] = tay_valid[NT];
   assign sq_tag[0]   = tay_tag[NT];
   assign sq_y[0]     = tay_y[NT];
   assign sq_side[0]  = tay_side[NT];
   assign sq_sat[0]   = tay_sat[NT];

   for (genvar i = 0; i < NS; i++) begin : g_square
      afu_square_step #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_step (
         .clock           (clock),
         .reset           (reset),
         .enable          (enable),
         .in_valid        (sq_valid[i]),
         .in_tag          (sq_tag[i]),
         .in_y            (sq_y[i]),
         .in_side_result  (sq_side[i]),
         .in_side_sat     (sq_sat[i]),
         .out_valid       (sq_valid[i+1]),
         .out_tag         (sq_tag[i+1]),
         .out_y           (sq_y[i+1]),
         .out_side_result (sq_side[i+1]),
         .out_side_sat    (sq_sat[i+1])
      );
   end

   logic                   dv_valid [0:ND];
   afu_pkg::tag_type       dv_tag   [0:ND];
   logic [QW-1:0]          dv_num   [0:ND];
   logic [QW-1:0]          dv_den   [0:ND];
   logic [DW-1:0]          dv_quot  [0:ND];
   logic [VALUE_WIDTH-1:0] dv_side  [0:ND];
   logic                   dv_sat   [0:ND];
   logic [QW-1:0]          exp_val;

   always_comb begin
      exp_val = sq_tag[NS].exp_zero ? '0 : sq_y[NS];
      if (sq_tag[NS].op == afu_pkg::OP_SIGMOID) begin
         dv_num[0] = sq_tag[NS].positive ? afu_pkg::ONE_Q62 : exp_val;
      end else begin
         dv_num[0] = afu_pkg::ONE_Q62 - exp_val;
      end
      dv_den[0] = afu_pkg::ONE_Q62 + exp_val;
   end

   assign dv_valid[0] = sq_valid[NS];
   assign dv_tag[0]   = sq_tag[NS];
   assign dv_quot[0]  = '0;
   assign dv_side[0]  = sq_side[NS];
   assign dv_sat[0]   = sq_sat[NS];

   for (genvar i = 0; i < ND; i++) begin : g_divide
      afu_div_step #(
         .VALUE_WIDTH   (VALUE_WIDTH),
         .FRACTION_BITS (FRACTION_BITS),
         .FIRST         (i == 0)
      ) u_step (
         .clock           (clock),
         .reset           (reset),
         .enable          (enable),
         .in_valid        (dv_valid[i]),
         .in_tag          (dv_tag[i]),
         .in_num          (dv_num[i]),
         .in_den          (dv_den[i]),
         .in_quot         (dv_quot[i]),
         .in_side_result  (dv_side[i]),
         .in_side_sat     (dv_sat[i]),
         .out_valid       (dv_valid[i+1]),
         .out_tag         (dv_tag[i+1]),
         .out_num         (dv_num[i+1]),
         .out_den         (dv_den[i+1]),
         .out_quot        (dv_quot[i+1]),
         .out_side_result (dv_side[i+1]),
         .out_side_sat    (dv_sat[i+1])
      );
   end

   logic [RW-1:0]          r_round, r_lim, r_sat;
   logic                   exp_sat;
   logic                   use_exp;
   logic [VALUE_WIDTH-1:0] exp_result;
   afu_pkg::tag_type       last_tag;

   always_comb begin
      last_tag   = dv_tag[ND];
      r_round    = (RW'(dv_quot[ND]) + RW'(1)) >> 1;
      r_lim      = (RW'(1) << (VALUE_WIDTH - 1)) - RW'(1) + RW'(last_tag.negate);
      exp_sat    = r_round > r_lim;
      r_sat      = exp_sat ? r_lim : r_round;
      exp_result = VALUE_WIDTH'(last_tag.negate ? (~r_sat + RW'(1)) : r_sat);
      use_exp    = (last_tag.op == afu_pkg::OP_SIGMOID) || (last_tag.op == afu_pkg::OP_TANH);
   end

   logic signed [VALUE_WIDTH-1:0] rsp_result_ff;
   logic                          rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_valid[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_result_ff <= use_exp ? exp_result : dv_side[ND];
         rsp_sat_ff    <= use_exp ? exp_sat : dv_sat[ND];
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.result    = rsp_result_ff;
   assign rsp_ch.saturated = rsp_sat_ff;
endmodule

### sim/afu_checker.sv
// Monitor, fixed-point prediction and in-order response checking for the activation unit.
module afu_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   afu_req_if                                   req,
   afu_rsp_if                                   rsp,
   input  logic                                 csr_we,
   input  logic [afu_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [afu_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output int                                   fails,
   output int                                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [23:0] value;
      logic        clipped;
   } activation_type;

   activation_type   expected_q[$];
   logic [23:0]      low_limit;
   logic [23:0]      high_limit;
   logic [22:0]      exp_limit;

   function automatic bit [63:0] q62_mul(bit [63:0] x, bit [63:0] y);
      bit [127:0] p;
      p = {64'b0, x} * {64'b0, y};
      return p[125:62];
   endfunction

   function automatic bit [63:0] exp_of_neg(bit [63:0] u);
      bit [63:0] term;
      bit [63:0] acc;
      bit [63:0] v;
      term = afu_pkg::ONE_Q62;
      acc = afu_pkg::ONE_Q62;
      if (u >= (64'd64 << 16)) return 64'd0;
      v = u << 38;
      for (int n = 1; n <= 20; n++) begin
         term = q62_mul(term, v) / n;
         if (n % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      for (int n = 0; n < 8; n++) acc = q62_mul(acc, acc);
      return acc;
   endfunction

   function automatic bit [63:0] rounded_quotient(bit [64:0] num, bit [64:0] den);
      bit [63:0] q;
      q = 0;
      if (num >= den) begin
         q = 1;
         num = num - den;
      end
      for (int i = 0; i < 17; i++) begin
         num = num << 1;
         q = q << 1;
         if (num >= den) begin
            num = num - den;
            q[0] = 1'b1;
         end
      end
      return (q + 1) >> 1;
   endfunction

   function automatic longint clip24(longint v, inout logic flag);
      if (v > 64'sd8388607) begin
         flag = 1'b1;
         return 64'sd8388607;
      end
      if (v < -64'sd8388608) begin
         flag = 1'b1;
         return -64'sd8388608;
      end
      return v;
   endfunction

   function automatic longint scaled_product(longint x, longint y, longint z,
                                             inout logic flag);
      bit         neg;
      bit [127:0] p;
      bit [127:0] lim;
      neg = (x < 0) ^ (y < 0) ^ (z < 0);
      p = 128'(x < 0 ? -x : x) * 128'(y < 0 ? -y : y);
      p = p * 128'(z < 0 ? -z : z);
      p = (p + (128'd1 << 31)) >> 32;
      lim = (128'd1 << 23) - (neg ? 0 : 1);
      if (p > lim) begin
         flag = 1'b1;
         p = lim;
      end
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic activation_type activation(afu_pkg::opcode_type op,
                                                 logic [23:0] a_raw,
                                                 logic [23:0] b_raw);
      longint         a;
      longint         b;
      longint         x;
      longint         lo;
      longint         hi;
      longint         r;
      bit [63:0]      y;
      logic           flag;
      activation_type res;
      a = longint'(signed'(a_raw));
      b = longint'(signed'(b_raw));
      lo = longint'(signed'(low_limit));
      hi = longint'(signed'(high_limit));
      flag = 1'b0;
      r = 0;
      case (op)
         afu_pkg::OP_RELU: r = a > 0 ? a : 0;
         afu_pkg::OP_SIGMOID: begin
            x = a < lo ? lo : (a > hi ? hi : a);
            y = exp_of_neg(x < 0 ? -x : x);
            r = longint'(rounded_quotient(x >= 0 ? afu_pkg::ONE_Q62 : y,
                                          afu_pkg::ONE_Q62 + y));
            r = clip24(r, flag);
         end
         afu_pkg::OP_TANH: begin
            x = -2 * a;
            if (x > longint'(exp_limit)) x = longint'(exp_limit);
            y = exp_of_neg(x < 0 ? -x : x);
            r = longint'(rounded_quotient(afu_pkg::ONE_Q62 - y, afu_pkg::ONE_Q62 + y));
            if (x > 0) r = -r;
            r = clip24(r, flag);
         end
         afu_pkg::OP_RELU_GRAD: r = b > 0 ? a : 0;
         afu_pkg::OP_SIGMOID_GRAD: r = scaled_product(a, b, 65536 - b, flag);
         afu_pkg::OP_TANH_GRAD: r = scaled_product(a, 65536 - b, 65536 + b, flag);
         default: r = a;
      endcase
      res.value = r[23:0];
      res.clipped = flag;
      return res;
   endfunction

   always @(posedge clock) begin
      activation_type exp_item;
      if (reset) begin
         low_limit <= afu_pkg::SIGMOID_LOW_RESET;
         high_limit <= afu_pkg::SIGMOID_HIGH_RESET;
         exp_limit <= afu_pkg::EXP_LIMIT_RESET;
         expected_q.delete();
         fails <= 0;
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (afu_pkg::csr_index_type'(csr_index))
               afu_pkg::CSR_SIGMOID_LOW: low_limit <= csr_wdata;
               afu_pkg::CSR_SIGMOID_HIGH: high_limit <= csr_wdata;
               afu_pkg::CSR_EXP_LIMIT: exp_limit <= csr_wdata[22:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            expected_q.push_back(activation(afu_pkg::opcode_type'(req.opcode),
                                            req.value_a, req.value_b));
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transfer result=%h saturated=%0b", $realtime,
                        rsp.result, rsp.saturated);
               fails <= fails + 1;
            end else begin
               exp_item = expected_q.pop_front();
               if (rsp.result !== exp_item.value || rsp.saturated !== exp_item.clipped) begin
                  $display({"%0t: mismatch expected result=%h saturated=%0b",
                            " actual result=%h saturated=%0b"},
                           $realtime, exp_item.value, exp_item.clipped, rsp.result,
                           rsp.saturated);
                  fails <= fails + 1;
               end
            end
         end
         pending <= expected_q.size();
      end
   end

endmodule

### sim/tb_activation_function_unit.sv
// Stimulus, clocking and verdict for the activation function unit testbench.
module tb_activation_function_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_POS = 8388607;
   localparam int MAX_NEG = -8388608;
   localparam int ONE = 65536;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_we;
   logic [afu_pkg::CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [afu_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata;
   int                                   fails;
   int                                   pending;
   int                                   cycles;
   int                                   stall_left;
   bit                                   no_idle;

   afu_req_if req ();
   afu_rsp_if rsp ();

   activation_function_unit uut (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   afu_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fails(fails), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [23:0] pick_value(bit gradient_b);
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 24'($urandom);
      if (r < 30) begin
         case ($urandom_range(0, 4))
            0: return 24'(MAX_POS);
            1: return 24'(MAX_NEG);
            2: return 24'(0);
            3: return 24'(ONE);
            default: return 24'(-1);
         endcase
      end
      if (gradient_b) return 24'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
      return 24'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp.ready <= ~reset;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) stall_left <= gap_len();
      end
   end

   task automatic send(afu_pkg::opcode_type op, logic [23:0] a, logic [23:0] b);
      int gap;
      req.valid <= 1'b1;
      req.opcode <= op;
      req.value_a <= a;
      req.value_b <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      gap = gap_len();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_limits(int low, int high, int exp_max);
      csr_we <= 1'b1;
      csr_index <= afu_pkg::CSR_SIGMOID_LOW;
      csr_wdata <= 24'(low);
      @(posedge clock);
      csr_index <= afu_pkg::CSR_SIGMOID_HIGH;
      csr_wdata <= 24'(high);
      @(posedge clock);
      csr_index <= afu_pkg::CSR_EXP_LIMIT;
      csr_wdata <= 24'(exp_max);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_items(int count);
      afu_pkg::opcode_type op;
      for (int i = 0; i < count; i++) begin
         op = afu_pkg::opcode_type'($urandom_range(0, 7));
         send(op, pick_value(1'b0), pick_value(op >= afu_pkg::OP_RELU_GRAD));
      end
   endtask

   initial begin
      reset = 1'b1;
      cycles = 0;
      no_idle = 1'b0;
      csr_we = 1'b0;
      csr_index = afu_pkg::CSR_SIGMOID_LOW;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.opcode = afu_pkg::OP_RELU;
      req.value_a = '0;
      req.value_b = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(afu_pkg::OP_RELU, 24'(MAX_POS), 24'(MAX_NEG));
      send(afu_pkg::OP_RELU, 24'(MAX_NEG), 24'(MAX_POS));
      send(afu_pkg::OP_RELU, 24'(0), 24'(0));
      send(afu_pkg::OP_SIGMOID, 24'(MAX_POS), 24'(0));
      send(afu_pkg::OP_SIGMOID, 24'(MAX_NEG), 24'(0));
      send(afu_pkg::OP_SIGMOID, 24'(0), 24'(0));
      send(afu_pkg::OP_SIGMOID, 24'(ONE), 24'(0));
      send(afu_pkg::OP_TANH, 24'(MAX_NEG), 24'(0));
      send(afu_pkg::OP_TANH, 24'(MAX_POS), 24'(0));
      send(afu_pkg::OP_TANH, 24'(0), 24'(0));
      send(afu_pkg::OP_TANH, 24'(-ONE / 2), 24'(0));
      send(afu_pkg::OP_IDENTITY, 24'(MAX_POS), 24'(MAX_NEG));
      send(afu_pkg::OP_IDENTITY, 24'(MAX_NEG), 24'(0));
      send(afu_pkg::OP_RELU_GRAD, 24'(MAX_NEG), 24'(1));
      send(afu_pkg::OP_RELU_GRAD, 24'(MAX_POS), 24'(0));
      send(afu_pkg::OP_SIGMOID_GRAD, 24'(MAX_POS), 24'(MAX_POS));
      send(afu_pkg::OP_SIGMOID_GRAD, 24'(MAX_NEG), 24'(MAX_NEG));
      send(afu_pkg::OP_SIGMOID_GRAD, 24'(ONE), 24'(ONE / 2));
      send(afu_pkg::OP_TANH_GRAD, 24'(MAX_POS), 24'(MAX_NEG));
      send(afu_pkg::OP_TANH_GRAD, 24'(MAX_NEG), 24'(ONE / 4));
      send(afu_pkg::OP_IDENTITY_GRAD, 24'(MAX_NEG), 24'(MAX_POS));
      random_items(150);
      drain();

      write_limits(MAX_NEG, MAX_POS, 0);
      random_items(150);
      drain();

      write_limits(5 * ONE, -3 * ONE, 8388607);
      send(afu_pkg::OP_SIGMOID, 24'(-4 * ONE), 24'(0));
      send(afu_pkg::OP_SIGMOID, 24'(6 * ONE), 24'(0));
      send(afu_pkg::OP_SIGMOID, 24'(ONE), 24'(0));
      random_items(150);
      drain();

      no_idle = 1'b1;
      write_limits(-3 * ONE / 2, 9 * ONE / 4, 3 * ONE);
      random_items(150);
      drain();

      if (fails == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/afu_pkg.sv
rtl/afu_if.sv
rtl/afu_front.sv
rtl/afu_taylor_step.sv
rtl/afu_square_step.sv
rtl/afu_div_step.sv
rtl/activation_function_unit.sv
sim/afu_checker.sv
sim/tb_activation_function_unit.sv
